[sv/mavg_pkg.sv]
// Shared types, constants and microcode store of the multichannel moving-average filter.
package mavg_pkg;

    localparam int SAMPLES_MAX_DEF  = 8;
    localparam int CHANNELS_MAX_DEF = 8;

    localparam int SAMPLE_BITS = 12;
    localparam int CH_W        = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int W_W         = 4;                       // window value, 1..15
    localparam int FRAC_BITS   = 8;
    localparam int AVG_W       = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_W       = SAMPLE_BITS + W_W;
    localparam int DIV_CNT_W   = $clog2(AVG_W + 1);

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 4'd7;
    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RST = 4'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0]        channel;
        logic [SAMPLE_BITS-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [AVG_W-1:0] average;
        logic             bad_channel;
    } result_t;

    // Sequencer steps
    typedef enum logic [2:0] {
        STEP_CLEAR    = 3'd0,
        STEP_FETCH    = 3'd1,
        STEP_WRITE    = 3'd2,
        STEP_READ     = 3'd3,
        STEP_ACC      = 3'd4,
        STEP_DIV_INIT = 3'd5,
        STEP_DIV      = 3'd6,
        STEP_EMIT     = 3'd7
    } step_t;

    // Branch conditions
    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_CLR_MORE  = 3'd2,
        COND_NO_ACCEPT = 3'd3,
        COND_BAD       = 3'd4,
        COND_MORE_RD   = 3'd5,
        COND_DIV_MORE  = 3'd6,
        COND_OUT_BUSY  = 3'd7
    } cond_t;

    // hold = 1: stay while cond, then go to target.
    // hold = 0: go to target if cond, else fall through to the next step.
    typedef struct packed {
        logic  clr_wr;
        logic  take;
        logic  hist_wr;
        logic  rd_issue;
        logic  acc_add;
        logic  div_init;
        logic  div_step;
        logic  emit;
        cond_t cond;
        logic  hold;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        unique case (step)
            STEP_CLEAR:
            begin
                w.clr_wr = 1'b1;
                w.cond   = COND_CLR_MORE;
                w.hold   = 1'b1;
                w.target = STEP_FETCH;
            end
            STEP_FETCH:
            begin
                w.take   = 1'b1;
                w.cond   = COND_NO_ACCEPT;
                w.hold   = 1'b1;
                w.target = STEP_WRITE;
            end
            STEP_WRITE:
            begin
                w.hist_wr = 1'b1;
                w.cond    = COND_BAD;
                w.target  = STEP_EMIT;
            end
            STEP_READ:
            begin
                w.rd_issue = 1'b1;
                w.cond     = COND_NEVER;
            end
            STEP_ACC:
            begin
                w.acc_add  = 1'b1;
                w.rd_issue = 1'b1;
                w.cond     = COND_MORE_RD;
                w.hold     = 1'b1;
                w.target   = STEP_DIV_INIT;
            end
            STEP_DIV_INIT:
            begin
                w.div_init = 1'b1;
                w.cond     = COND_NEVER;
            end
            STEP_DIV:
            begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.hold     = 1'b1;
                w.target   = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.hold   = 1'b1;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

[sv/mavg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mavg_ram
#(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/multichannel_moving_average_top.sv]
// Top level of the multichannel moving-average filter: microcoded sequencer and datapath.
//
// Channels
//   item (item_valid/item_ready/item): one converter sample for one channel per transaction.
//   result (result_valid/result_ready/result): one transaction per item, in order: channel,
//   window mean (8 fractional bits, truncated), bad-channel flag.
//   cfg (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 window length, index 1 channel
//   count, other indexes ignored; cfg_ready is always high; write only with no item in flight.
// Sequence
//   A good item's history is read one entry at a time on the single RAM read port, then a
//   restoring divider gives one quotient bit per cycle, and result_valid rises from the
//   emit step. For a rejected channel the write step leads straight to the emit step.
//   One item is in work at a time; the next is taken in the cycle after its result is
//   registered, so no new item is taken before the last one is through.
// Reset
//   History RAM is swept to zero, one entry per cycle (CHANNELS_MAX * SAMPLES_MAX entries,
//   64 by default) with item_ready low; write positions and configuration reset at once.
// Stall
//   With result_ready low the result holds; the sequencer waits in its emit step and accepts
//   nothing further until the result register frees.
module multichannel_moving_average_top
    import mavg_pkg::*;
#(
    parameter int SAMPLES_MAX  = SAMPLES_MAX_DEF,
    parameter int CHANNELS_MAX = CHANNELS_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int DEPTH  = CHANNELS_MAX * SAMPLES_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = (SAMPLES_MAX > 1) ? $clog2(SAMPLES_MAX) : 1;
    localparam int CH_AW  = (CHANNELS_MAX > 1) ? $clog2(CHANNELS_MAX) : 1;

    // configuration
    logic [CFG_W-1:0] window_length_reg, window_length_next;
    logic [CFG_W-1:0] channel_count_reg, channel_count_next;

    // sequencer
    step_t  step_reg, step_next;
    ucode_t uw;
    logic   cond_true;

    // datapath registers
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                   bad_reg, bad_next;
    logic [W_W-1:0]         w_reg, w_next;
    logic [W_W-1:0]         idx_reg, idx_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [W_W-1:0]         rem_reg, rem_next;
    logic [AVG_W-1:0]       dq_reg, dq_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [POS_W-1:0]       wpos_reg [CHANNELS_MAX];
    logic [POS_W-1:0]       wpos_next [CHANNELS_MAX];
    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;

    // combinational helpers
    logic [W_W-1:0]         win_use;
    logic [CH_AW-1:0]       ch_idx;
    logic [POS_W-1:0]       wpos_cur;
    logic [POS_W-1:0]       pos_eff;
    logic [POS_W:0]         pos_inc;
    logic [POS_W-1:0]       pos_adv;
    logic                   more_rd;
    logic                   out_busy;
    logic [W_W:0]           trial;
    logic                   qbit;

    // RAM port
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready    = 1'b1;
    assign item_ready   = uw.take;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // window in use: 0 reads as 1, above the store depth clamps to it
    always_comb
    begin
        win_use = window_length_reg;
        if (window_length_reg == '0)
        begin
            win_use = W_W'(1);
        end
        else if (32'(window_length_reg) > SAMPLES_MAX)
        begin
            win_use = W_W'(SAMPLES_MAX);
        end
    end

    // write position of the current channel; a shrunk window restarts at slot 0
    assign ch_idx   = CH_AW'(ch_reg);
    assign wpos_cur = wpos_reg[ch_idx];
    assign pos_eff  = (32'(wpos_cur) >= 32'(w_reg)) ? '0 : wpos_cur;
    assign pos_inc  = {1'b0, pos_eff} + (POS_W + 1)'(1);
    assign pos_adv  = (32'(pos_inc) >= 32'(w_reg)) ? '0 : POS_W'(pos_inc);

    assign more_rd  = (idx_reg != w_reg);
    assign out_busy = result_valid_reg && !result_ready;

    // restoring divide by the window, one quotient bit per step
    assign trial = {rem_reg, dq_reg[AVG_W-1]};
    assign qbit  = (trial >= {1'b0, w_reg});

    // RAM access
    assign ram_we    = uw.clr_wr || (uw.hist_wr && !bad_reg);
    assign ram_waddr = uw.clr_wr ? clr_addr_reg
                                 : ADDR_W'(32'(ch_reg) * SAMPLES_MAX + 32'(pos_eff));
    assign ram_wdata = uw.clr_wr ? '0 : smp_reg;
    assign ram_raddr = ADDR_W'(32'(ch_reg) * SAMPLES_MAX + 32'(idx_reg));

    // control word decode and branch condition
    always_comb
    begin
        uw = ucode_rom(step_reg);
        unique case (uw.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_CLR_MORE:  cond_true = (clr_addr_reg != ADDR_W'(DEPTH - 1));
            COND_NO_ACCEPT: cond_true = !item_valid;
            COND_BAD:       cond_true = bad_reg;
            COND_MORE_RD:   cond_true = more_rd;
            COND_DIV_MORE:  cond_true = (div_cnt_reg != DIV_CNT_W'(1));
            COND_OUT_BUSY:  cond_true = out_busy;
        endcase
    end

    // step counter
    always_comb
    begin
        if (uw.hold)
        begin
            step_next = cond_true ? step_reg : uw.target;
        end
        else
        begin
            step_next = cond_true ? uw.target : step_t'(3'(step_reg + 3'd1));
        end
    end

    // configuration writes
    always_comb
    begin
        window_length_next = window_length_reg;
        channel_count_next = channel_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH: window_length_next = cfg_data;
                CFG_CHANNEL_COUNT: channel_count_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_comb
    begin
        ch_next           = ch_reg;
        smp_next          = smp_reg;
        bad_next          = bad_reg;
        w_next            = w_reg;
        idx_next          = idx_reg;
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        dq_next           = dq_reg;
        div_cnt_next      = div_cnt_reg;
        clr_addr_next     = clr_addr_reg;
        wpos_next         = wpos_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (uw.clr_wr)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end

        if (uw.take && item_valid)
        begin
            ch_next  = item.channel;
            smp_next = item.sample;
            bad_next = (CFG_W'(item.channel) >= channel_count_reg)
                    || (32'(item.channel) >= CHANNELS_MAX);
            w_next   = win_use;
        end

        if (uw.hist_wr)
        begin
            acc_next = '0;
            idx_next = '0;
            if (!bad_reg)
            begin
                wpos_next[ch_idx] = pos_adv;
            end
        end

        if (uw.rd_issue && more_rd)
        begin
            idx_next = idx_reg + W_W'(1);
        end

        if (uw.acc_add)
        begin
            acc_next = acc_reg + SUM_W'(ram_rdata);
        end

        // numerator is sum << 8; its top W_W bits are below the window
        if (uw.div_init)
        begin
            rem_next     = acc_reg[SUM_W-1 -: W_W];
            dq_next      = {acc_reg[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
            div_cnt_next = DIV_CNT_W'(AVG_W);
        end

        if (uw.div_step)
        begin
            rem_next     = qbit ? W_W'(trial - {1'b0, w_reg}) : trial[W_W-1:0];
            dq_next      = {dq_reg[AVG_W-2:0], qbit};
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
        end

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        if (uw.emit && !out_busy)
        begin
            result_valid_next       = 1'b1;
            result_next.out_channel = ch_reg;
            result_next.average     = bad_reg ? '0 : dq_reg;
            result_next.bad_channel = bad_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= STEP_CLEAR;
            window_length_reg <= WINDOW_LENGTH_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
            bad_reg           <= 1'b0;
            clr_addr_reg      <= '0;
            result_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS_MAX; i++)
            begin
                wpos_reg[i] <= '0;
            end
        end
        else
        begin
            step_reg          <= step_next;
            window_length_reg <= window_length_next;
            channel_count_reg <= channel_count_next;
            bad_reg           <= bad_next;
            clr_addr_reg      <= clr_addr_next;
            result_valid_reg  <= result_valid_next;
            wpos_reg          <= wpos_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        smp_reg     <= smp_next;
        w_reg       <= w_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        div_cnt_reg <= div_cnt_next;
        result_reg  <= result_next;
    end

    // checks
    a_accept_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> step_reg == STEP_WRITE)
        else $error("accepted item did not move to the write step");

    a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (step_reg == STEP_CLEAR) || (step_reg == STEP_WRITE && !bad_reg))
        else $error("history written outside clear sweep or good-item write");

    a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_ACC |-> idx_reg != '0 && idx_reg <= w_reg)
        else $error("history read index outside the window");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_DIV |-> rem_reg < w_reg)
        else $error("divider remainder not below the window");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_channel |-> result.average == '0)
        else $error("rejected channel reported a non-zero average");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the multichannel moving-average filter.
module tb_top;
    import mavg_pkg::*;

    // Channel and window limits of the default build
    localparam int CHANNELS = CHANNELS_MAX_DEF;
    localparam int SAMPLES  = SAMPLES_MAX_DEF;

    // Register indexes with no register behind them; writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Idle cycles allowed after the last result before a register write or the end.
    // Every item yields a result, so a handful is plenty between phases.
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 40;

    // Watchdog: longest run of cycles with no transaction on any channel.
    // Worst legitimate gap is the RAM sweep after reset, or the work on one item plus
    // a long run of receiver stalls; this leaves a wide margin.
    localparam int STALL_LIMIT = 3000;

    // Cap on printed mismatch lines; all mismatches are still counted
    localparam int MAX_REPORTS = 50;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]       cfg_data     = '0;

    multichannel_moving_average_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the filter: configuration, sample rings and write positions
    logic [CFG_W-1:0]       window_reg     = WINDOW_LENGTH_RST;
    logic [CFG_W-1:0]       chan_count_reg = CHANNEL_COUNT_RST;
    logic [SAMPLE_BITS-1:0] sample_ring [CHANNELS][SAMPLES];
    logic [CH_W-1:0]        ring_pos    [CHANNELS];

    // Samples waiting to be driven, and averages waiting to come out
    item_t   pending_samples[$];
    result_t expected_averages[$];

    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      error_count    = 0;
    int      quiet_cycles   = 0;
    bit      sample_taken;
    result_t want_result;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Works out the result of one accepted sample and updates the shadow state.
    // Rejected channels leave rings and positions untouched.
    function automatic result_t predict_average(input item_t it);
        result_t                          r;
        logic [CFG_W-1:0]                 span;
        logic [CFG_W-1:0]                 slot;
        logic [CFG_W-1:0]                 next_slot;
        logic [SUM_W-1:0]                 total;
        logic [SUM_W+FRAC_BITS-1:0]       scaled;
        logic [SUM_W+FRAC_BITS-1:0]       quotient;
        r             = '0;
        r.out_channel = it.channel;
        if ({1'b0, it.channel} >= chan_count_reg)
        begin
            r.bad_channel = 1'b1;
            return r;
        end
        // Out-of-range window settings are clipped to 1..SAMPLES
        span = window_reg;
        if (span == '0)
            span = CFG_W'(1);
        if (span > SAMPLES)
            span = CFG_W'(SAMPLES);
        // After the window has shrunk the stale position restarts at slot 0
        slot = {1'b0, ring_pos[it.channel]};
        if (slot >= span)
            slot = '0;
        sample_ring[it.channel][slot[CH_W-1:0]] = it.sample;
        next_slot = slot + 1'b1;
        if (next_slot >= span)
            next_slot = '0;
        ring_pos[it.channel] = next_slot[CH_W-1:0];
        // Entries past an older, shorter window still count once it grows again
        total = '0;
        for (int i = 0; i < span; i++)
            total += sample_ring[it.channel][i];
        scaled   = {total, {FRAC_BITS{1'b0}}};
        quotient = scaled / span;
        r.average = quotient[AVG_W-1:0];
        return r;
    endfunction

    // Driver: presents queued samples, holding each until the transaction completes.
    // Sender idling is drawn per cycle while no sample is outstanding.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            sample_taken = item_valid && item_ready;
            if (sample_taken)
                expected_averages.push_back(predict_average(item));
            if (!item_valid || sample_taken)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item       <= pending_samples.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result transaction is checked against the oldest expectation.
    // result_ready is redrawn every cycle for receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_averages.size() == 0)
                begin
                    report_error($sformatf("result with nothing expected: ch %0d avg %0d bad %0b",
                                           result.out_channel, result.average,
                                           result.bad_channel));
                end
                else
                begin
                    want_result = expected_averages.pop_front();
                    if (result.out_channel !== want_result.out_channel)
                        report_error($sformatf("out_channel %0d, expected %0d",
                                               result.out_channel, want_result.out_channel));
                    if (result.average !== want_result.average)
                        report_error($sformatf("ch %0d average %0d, expected %0d",
                                               want_result.out_channel, result.average,
                                               want_result.average));
                    if (result.bad_channel !== want_result.bad_channel)
                        report_error($sformatf("ch %0d bad_channel %0b, expected %0b",
                                               want_result.out_channel, result.bad_channel,
                                               want_result.bad_channel));
                end
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run if no transaction of any kind completes for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One register write; the shadow copy follows once the transaction completes.
    // Starts on a fresh edge so back-to-back writes never reassign cfg_valid in one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WINDOW_LENGTH: window_reg     = val;
            CFG_CHANNEL_COUNT: chan_count_reg = val;
            default:           ;
        endcase
    endtask

    // Waits until every queued sample has gone in and every result has come out.
    // Sampled on the falling edge so the driver's updates of the rising edge are settled.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || item_valid || expected_averages.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_BITS-1:0] smp);
        item_t it;
        it.channel = ch;
        it.sample  = smp;
        pending_samples.push_back(it);
    endtask

    // Random phase under one register setting and one idling mode. Most samples go
    // to channels in use; about one in ten picks any channel and may be rejected.
    task automatic run_phase(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] chans,
                             input int n_items, input int send_pct, input int stall_pct);
        int in_use;
        write_reg(CFG_WINDOW_LENGTH, win);
        write_reg(CFG_CHANNEL_COUNT, chans);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        in_use = (chans == '0) ? 1 : ((chans > CHANNELS) ? CHANNELS : chans);
        repeat (n_items)
        begin
            case ($urandom_range(9))
                0:       queue_sample(CH_W'($urandom_range(in_use - 1)), '0);
                1:       queue_sample(CH_W'($urandom_range(in_use - 1)), '1);
                2:       queue_sample(CH_W'($urandom_range(CHANNELS - 1)),
                                      SAMPLE_BITS'($urandom_range(4095)));
                default: queue_sample(CH_W'($urandom_range(in_use - 1)),
                                      SAMPLE_BITS'($urandom_range(4095)));
            endcase
        end
        wait_quiet();
    endtask

    initial
    begin
        foreach (sample_ring[c, s])
            sample_ring[c][s] = '0;
        foreach (ring_pos[c])
            ring_pos[c] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset setting (window 7, five channels).
        // Seven full-scale samples fill channel 0 for the largest possible mean.
        repeat (7) queue_sample(3'd0, 12'hFFF);
        queue_sample(3'd1, 12'h000);
        queue_sample(3'd2, 12'hAAA);
        queue_sample(3'd3, 12'h555);
        queue_sample(3'd4, 12'h001);
        // Channels at and above the count are rejected without touching state
        queue_sample(3'd5, 12'hFFF);
        queue_sample(3'd6, 12'h000);
        queue_sample(3'd7, 12'hFFF);
        // Ring wraps: the oldest full-scale entry of channel 0 is overwritten
        queue_sample(3'd0, 12'h000);
        queue_sample(3'd4, 12'hFFE);
        wait_quiet();

        // Writes to unused indexes must leave both registers alone
        write_reg(CFG_SPARE_LO, 4'h0);
        write_reg(CFG_SPARE_HI, 4'hF);

        // Shrink to one, then grow to eight so stale entries count again;
        // zero and fifteen exercise the clipping of the window setting.
        run_phase(4'd1,  4'd8,  120, 0,  0);
        run_phase(4'd8,  4'd8,  130, 66, 0);
        run_phase(4'd0,  4'd3,  100, 0,  66);
        run_phase(4'd15, 4'd8,  130, 20, 20);
        // No channel in use: every sample is rejected
        run_phase(4'd4,  4'd0,  120, 0,  0);
        run_phase(4'd8,  4'd1,  100, 66, 0);
        run_phase(4'd3,  4'd15, 130, 0,  66);
        run_phase(4'd5,  4'd8,  100, 20, 20);

        repeat (END_CYCLES) @(posedge clk);
        if (expected_averages.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_averages.size()));

        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/mavg_pkg.sv
sv/mavg_ram.sv
sv/multichannel_moving_average_top.sv
tb/sv/tb_top.sv
